### hw/rtl/triangle_negative_region_integral_defines.svh
// ----------------------------------------------------------------------------
// triangle negative region integral - assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NEGATIVE_REGION_INTEGRAL_DEFINES_SVH
`define TRIANGLE_NEGATIVE_REGION_INTEGRAL_DEFINES_SVH

`ifndef SYNTHESIS
// plain property check under reset
`define TNRI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication check under reset
`define TNRI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `TNRI_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)
`else
`define TNRI_ASSERT(lbl, clk, rstn, prop, msg)
`define TNRI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### hw/rtl/tnri_pkg.sv
// ----------------------------------------------------------------------------
// tnri_pkg
// shared types and constants of the triangle negative region integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tnri_pkg;

  localparam int FIELD_W = 32;
  localparam int N_FIELD = 12;
  localparam int THR_W   = 16;
  localparam int OUT_W   = 64;
  localparam int TW      = 31;   // crossing parameter, unsigned q1.30
  localparam int MW      = 33;   // edge difference magnitude
  localparam int QDEPTH  = 2;

  // coordinate index inside a point
  localparam int CX = 0;
  localparam int CY = 1;
  localparam int CF = 2;
  localparam int CP = 3;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,   // no negative level
    KIND_ONE  = 2'd1,   // one negative vertex
    KIND_TWO  = 2'd2,   // two negative vertices
    KIND_ALL  = 2'd3    // whole triangle negative
  } kind_e;

  typedef logic [2:0][FIELD_W-1:0] pt_t;   // x, y, f
  typedef logic [3:0][FIELD_W-1:0] vp_t;   // x, y, f, level
  typedef pt_t [2:0] pts_t;
  typedef vp_t [2:0] vps_t;

  typedef struct packed {
    logic [2:0]         neg;
    logic [2:0][MW-1:0] mag;
  } ln_t;

  typedef struct packed {
    kind_e kind;
    pts_t  v;
    pt_t   aa;    // base point of crossing a
    ln_t   ea;    // edge of crossing a
    ln_t   eb;    // edge of crossing b, based at vertex 0
  } geo_t;

  typedef struct packed {
    geo_t                geo;
    logic [FIELD_W-1:0]  num_a;
    logic [FIELD_W-1:0]  den_a;
    logic [FIELD_W-1:0]  num_b;
    logic [FIELD_W-1:0]  den_b;
  } job_t;

endpackage

### hw/rtl/tnri_front.sv
// ----------------------------------------------------------------------------
// tnri_front
// input stage: sign extend, level nudge, sort by level, classify
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_negative_region_integral_defines.svh"

module tnri_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [tnri_pkg::THR_W-1:0]                  thr_i,
  input  logic                                        s_tvalid_i,
  output logic                                        s_tready_o,
  input  logic [tnri_pkg::N_FIELD*tnri_pkg::FIELD_W-1:0] s_tdata_i,
  input  logic                                        full_i,
  output logic                                        push_o,
  output tnri_pkg::job_t                              job_o
);
  import tnri_pkg::*;

  localparam int InW   = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
  localparam int ExtSh = FIELD_W - InW;
  localparam int NF    = 6;

  typedef struct packed {
    kind_e                  kind;
    vps_t                   v;
    pt_t                    aa;
    logic [2:0][MW-1:0]     da;
    logic [2:0][MW-1:0]     db;
    logic [FIELD_W-1:0]     na;
    logic [FIELD_W-1:0]     dna;
    logic [FIELD_W-1:0]     nb;
    logic [FIELD_W-1:0]     dnb;
  } pre_t;

  logic [NF-1:0] vld_q;
  logic          en;
  vps_t          st_q [4];
  logic [1:0]    ng_q [4];
  vps_t          in_v;
  logic [1:0]    in_ng;
  pre_t          pre_d, pre_q;
  job_t          job_d, job_q;

  function automatic vps_t cswap(input vps_t v, input int i, input int j);
    vps_t o;
    o = v;
    if ($signed(v[i][CP]) > $signed(v[j][CP])) begin
      o[i] = v[j];
      o[j] = v[i];
    end
    return o;
  endfunction

  assign en         = !(vld_q[NF-1] && full_i);
  assign s_tready_o = en;
  assign push_o     = vld_q[NF-1] && !full_i;
  assign job_o      = job_q;

  // sign extension and nudge of near zero levels
  always_comb begin
    logic [FIELD_W-1:0] sh;
    logic [FIELD_W-1:0] fld [N_FIELD];
    logic [FIELD_W-1:0] pv;
    logic [FIELD_W-1:0] pmag;
    for (int i = 0; i < N_FIELD; i++) begin
      sh     = s_tdata_i[i*FIELD_W +: FIELD_W] << ExtSh;
      fld[i] = $signed(sh) >>> ExtSh;
    end
    in_ng = '0;
    for (int v = 0; v < 3; v++) begin
      in_v[v][CX] = fld[2*v];
      in_v[v][CY] = fld[2*v+1];
      in_v[v][CF] = fld[6+v];
      pv          = fld[9+v];
      pmag        = pv[FIELD_W-1] ? (~pv + 1'b1) : pv;
      if (pmag < {{(FIELD_W-THR_W){1'b0}}, thr_i}) begin
        in_v[v][CP] = FIELD_W'(1);
      end else begin
        in_v[v][CP] = pv;
      end
      in_ng = in_ng + {1'b0, in_v[v][CP][FIELD_W-1]};
    end
  end

  // crossing edges and differences
  always_comb begin
    vps_t s;
    vp_t  a;
    vp_t  b;
    s = st_q[3];
    case (ng_q[3])
      2'd0:    pre_d.kind = KIND_ZERO;
      2'd1:    pre_d.kind = KIND_ONE;
      2'd2:    pre_d.kind = KIND_TWO;
      default: pre_d.kind = KIND_ALL;
    endcase
    a = (pre_d.kind == KIND_ONE) ? s[0] : s[1];
    b = (pre_d.kind == KIND_ONE) ? s[1] : s[2];
    pre_d.v = s;
    for (int c = 0; c < 3; c++) begin
      pre_d.aa[c] = a[c];
      pre_d.da[c] = {b[c][FIELD_W-1], b[c]} - {a[c][FIELD_W-1], a[c]};
      pre_d.db[c] = {s[2][c][FIELD_W-1], s[2][c]} - {s[0][c][FIELD_W-1], s[0][c]};
    end
    pre_d.na  = '0 - a[CP];
    pre_d.dna = b[CP] - a[CP];
    pre_d.nb  = '0 - s[0][CP];
    pre_d.dnb = s[2][CP] - s[0][CP];
  end

  // magnitudes and signs of edge differences
  always_comb begin
    job_d.geo.kind = pre_q.kind;
    job_d.geo.aa   = pre_q.aa;
    for (int v = 0; v < 3; v++) begin
      for (int c = 0; c < 3; c++) begin
        job_d.geo.v[v][c] = pre_q.v[v][c];
      end
    end
    for (int c = 0; c < 3; c++) begin
      job_d.geo.ea.neg[c] = pre_q.da[c][MW-1];
      job_d.geo.ea.mag[c] = pre_q.da[c][MW-1] ? ('0 - pre_q.da[c]) : pre_q.da[c];
      job_d.geo.eb.neg[c] = pre_q.db[c][MW-1];
      job_d.geo.eb.mag[c] = pre_q.db[c][MW-1] ? ('0 - pre_q.db[c]) : pre_q.db[c];
    end
    job_d.num_a = pre_q.na;
    job_d.den_a = pre_q.dna;
    job_d.num_b = pre_q.nb;
    job_d.den_b = pre_q.dnb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NF-2:0], s_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= in_v;
      ng_q[0] <= in_ng;
      st_q[1] <= cswap(st_q[0], 0, 1);
      st_q[2] <= cswap(st_q[1], 0, 2);
      st_q[3] <= cswap(st_q[2], 1, 2);
      for (int i = 1; i < 4; i++) begin
        ng_q[i] <= ng_q[i-1];
      end
      pre_q <= pre_d;
      job_q <= job_d;
    end
  end

  `TNRI_ASSERT_IMP(a_front_cross_num, clk_i, rst_ni, vld_q[NF-1] && job_q.geo.kind == KIND_ONE, job_q.num_a != '0 && job_q.num_a <= job_q.den_a, "crossing numerator out of range")

endmodule

### hw/rtl/tnri_queue.sv
// ----------------------------------------------------------------------------
// tnri_queue
// two entry queue between the classifier and the arithmetic pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_negative_region_integral_defines.svh"

module tnri_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tnri_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           vld_o,
  output tnri_pkg::job_t job_o
);
  import tnri_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t              mem_q [QDEPTH];
  logic [PW-1:0]     wp_q, rp_q;
  logic [PW:0]       cnt_q, cnt_d;

  assign full_o = (cnt_q == (PW+1)'(QDEPTH));
  assign vld_o  = (cnt_q != '0);
  assign job_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  `TNRI_ASSERT_IMP(a_queue_no_overrun, clk_i, rst_ni, push_i, !full_o || pop_i, "push into full queue")
  `TNRI_ASSERT_IMP(a_queue_no_underrun, clk_i, rst_ni, pop_i, vld_o, "pop from empty queue")

endmodule

### hw/rtl/tnri_back.sv
// ----------------------------------------------------------------------------
// tnri_back
// arithmetic pipeline: crossing divide, interpolation, area terms, scaling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_negative_region_integral_defines.svh"

module tnri_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        jvld_i,
  input  tnri_pkg::job_t              job_i,
  output logic                        pop_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [tnri_pkg::OUT_W-1:0]  m_tdata_o
);
  import tnri_pkg::*;

  localparam int NDIV = TW;            // one quotient bit per stage
  localparam int ND6  = 9;             // divide by six, eight bits per stage
  localparam int D6W  = 8 * ND6;
  localparam int NSTG = NDIV + 1 + 12 + ND6;
  localparam int SLO  = 22;            // slice width of the area product

  typedef struct packed {
    logic [MW-1:0]      rem;
    logic [FIELD_W-1:0] den;
    logic [TW-1:0]      q;
  } dv_t;

  typedef struct packed {
    logic signed [MW-1:0] bx, cy, cx, by;
    logic signed [MW:0]   fs;
  } td_t;

  typedef struct packed {
    logic [D6W-1:0] dd;
    logic [D6W-1:0] quot;
    logic [2:0]     rem;
    logic           neg;
  } d6_t;

  logic              en;
  logic [NSTG-1:0]   vld_q;
  logic              out_vld_q;
  logic [OUT_W-1:0]  out_q;

  dv_t               dva_q [NDIV+1];
  dv_t               dvb_q [NDIV+1];
  geo_t              geo_q [NDIV+1];

  logic [63:0]       pra_q [3];
  logic [63:0]       prb_q [3];
  geo_t              l1_geo_q;
  pt_t               xa_q, xb_q;
  kind_e             kd_q [7];
  pts_t              l2_v_q;
  td_t               td_q [2];
  logic signed [2*MW-1:0] e1_q [2], e2_q [2];
  logic signed [MW:0]     fs2_q [2], fs3_q [2];
  logic [2*MW:0]          cr_q [2];
  logic [2*MW-1:0]        cm_q [2];
  logic [MW-1:0]          fm_q [2];
  logic                   fn_q [2], fn5_q [2], fn6_q [2];
  logic [SLO+MW-1:0]      pp_q [2][3];
  logic [3*SLO+MW-1:0]    tm_q [2];
  logic [3*SLO+MW:0]      tv_q [2];
  logic [3*SLO+MW+1:0]    tot_q;
  logic [3*SLO+MW:0]      tmag_q;
  logic                   tneg_q;
  d6_t                    d6_q [ND6+1];

  pt_t                    xa_d, xb_d;
  td_t                    td_d [2];
  d6_t                    d6_in;

  function automatic dv_t dv_step(input dv_t d, input logic first);
    dv_t           o;
    logic [MW-1:0] r;
    o = d;
    r = first ? d.rem : {d.rem[MW-2:0], 1'b0};
    if (r >= {1'b0, d.den}) begin
      o.rem = r - {1'b0, d.den};
      o.q   = {d.q[TW-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.q   = {d.q[TW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic d6_t d6_step(input d6_t d, input logic [7:0] bits);
    d6_t        o;
    logic [3:0] r;
    o = d;
    for (int b = 7; b >= 0; b--) begin
      r = {o.rem, bits[b]};
      if (r >= 4'd6) begin
        r      = r - 4'd6;
        o.quot = {o.quot[D6W-2:0], 1'b1};
      end else begin
        o.quot = {o.quot[D6W-2:0], 1'b0};
      end
      o.rem = r[2:0];
    end
    return o;
  endfunction

  function automatic logic [FIELD_W-1:0] lerp_fin(input logic [FIELD_W-1:0] a,
                                                  input logic [63:0] prod,
                                                  input logic neg);
    logic [63:0]        rnd;
    logic [FIELD_W+2:0] base;
    logic [FIELD_W+2:0] res;
    rnd  = prod + 64'(1 << 29);
    base = {{3{a[FIELD_W-1]}}, a};
    res  = neg ? (base - {1'b0, rnd[63:30]}) : (base + {1'b0, rnd[63:30]});
    return res[FIELD_W-1:0];
  endfunction

  function automatic td_t tri_diff(input pt_t a, input pt_t b, input pt_t c);
    td_t o;
    o.bx = {b[CX][FIELD_W-1], b[CX]} - {a[CX][FIELD_W-1], a[CX]};
    o.by = {b[CY][FIELD_W-1], b[CY]} - {a[CY][FIELD_W-1], a[CY]};
    o.cx = {c[CX][FIELD_W-1], c[CX]} - {a[CX][FIELD_W-1], a[CX]};
    o.cy = {c[CY][FIELD_W-1], c[CY]} - {a[CY][FIELD_W-1], a[CY]};
    o.fs = {{2{a[CF][FIELD_W-1]}}, a[CF]} + {{2{b[CF][FIELD_W-1]}}, b[CF]}
         + {{2{c[CF][FIELD_W-1]}}, c[CF]};
    return o;
  endfunction

  assign en         = !out_vld_q || m_tready_i;
  assign pop_o      = en && jvld_i;
  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_q;

  // crossing points from the registered products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      xa_d[c] = lerp_fin(l1_geo_q.aa[c],   pra_q[c], l1_geo_q.ea.neg[c]);
      xb_d[c] = lerp_fin(l1_geo_q.v[0][c], prb_q[c], l1_geo_q.eb.neg[c]);
    end
  end

  // sub-triangle edges: first one by kind, second only for two negatives
  always_comb begin
    case (kd_q[0])
      KIND_ONE: td_d[0] = tri_diff(l2_v_q[0], xa_q, xb_q);
      KIND_TWO: td_d[0] = tri_diff(l2_v_q[0], l2_v_q[1], xa_q);
      default:  td_d[0] = tri_diff(l2_v_q[0], l2_v_q[1], l2_v_q[2]);
    endcase
    td_d[1] = tri_diff(l2_v_q[0], xb_q, xa_q);
  end

  // rounding bias and alignment of the total before the divide by six
  always_comb begin
    logic [3*SLO+MW+1:0] m;
    m          = {1'b0, tmag_q} + ((3*SLO+MW+2)'(3) << 32);
    d6_in.dd   = D6W'(m[3*SLO+MW+1:32]);
    d6_in.quot = '0;
    d6_in.rem  = '0;
    d6_in.neg  = tneg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NSTG-2:0], jvld_i};
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // crossing divides
      dva_q[0] <= '{rem: {1'b0, job_i.num_a}, den: job_i.den_a, q: '0};
      dvb_q[0] <= '{rem: {1'b0, job_i.num_b}, den: job_i.den_b, q: '0};
      geo_q[0] <= job_i.geo;
      for (int i = 0; i < NDIV; i++) begin
        dva_q[i+1] <= dv_step(dva_q[i], (i == 0));
        dvb_q[i+1] <= dv_step(dvb_q[i], (i == 0));
        geo_q[i+1] <= geo_q[i];
      end
      // interpolation products
      for (int c = 0; c < 3; c++) begin
        pra_q[c] <= 64'(geo_q[NDIV].ea.mag[c]) * 64'(dva_q[NDIV].q);
        prb_q[c] <= 64'(geo_q[NDIV].eb.mag[c]) * 64'(dvb_q[NDIV].q);
      end
      l1_geo_q <= geo_q[NDIV];
      xa_q     <= xa_d;
      xb_q     <= xb_d;
      l2_v_q   <= l1_geo_q.v;
      kd_q[0]  <= l1_geo_q.kind;
      for (int i = 1; i < 7; i++) begin
        kd_q[i] <= kd_q[i-1];
      end
      // area and value sum of each sub-triangle
      for (int t = 0; t < 2; t++) begin
        td_q[t]  <= td_d[t];
        e1_q[t]  <= td_q[t].bx * td_q[t].cy;
        e2_q[t]  <= td_q[t].cx * td_q[t].by;
        fs2_q[t] <= td_q[t].fs;
        cr_q[t]  <= {e1_q[t][2*MW-1], e1_q[t]} - {e2_q[t][2*MW-1], e2_q[t]};
        fs3_q[t] <= fs2_q[t];
        cm_q[t]  <= cr_q[t][2*MW] ? (2*MW)'('0 - cr_q[t]) : cr_q[t][2*MW-1:0];
        fm_q[t]  <= fs3_q[t][MW] ? MW'('0 - fs3_q[t]) : fs3_q[t][MW-1:0];
        fn_q[t]  <= fs3_q[t][MW];
        for (int k = 0; k < 3; k++) begin
          pp_q[t][k] <= (SLO+MW)'(cm_q[t][k*SLO +: SLO]) * (SLO+MW)'(fm_q[t]);
        end
        fn5_q[t] <= fn_q[t];
        tm_q[t]  <= (3*SLO+MW)'(pp_q[t][0])
                  + ((3*SLO+MW)'(pp_q[t][1]) << SLO)
                  + ((3*SLO+MW)'(pp_q[t][2]) << (2*SLO));
        fn6_q[t] <= fn5_q[t];
      end
      // signed terms, zero where the sub-triangle does not exist
      tv_q[0] <= (kd_q[6] == KIND_ZERO) ? '0 :
                 (fn6_q[0] ? ('0 - {1'b0, tm_q[0]}) : {1'b0, tm_q[0]});
      tv_q[1] <= (kd_q[6] != KIND_TWO) ? '0 :
                 (fn6_q[1] ? ('0 - {1'b0, tm_q[1]}) : {1'b0, tm_q[1]});
      tot_q   <= {tv_q[0][3*SLO+MW], tv_q[0]} + {tv_q[1][3*SLO+MW], tv_q[1]};
      tneg_q  <= tot_q[3*SLO+MW+1];
      tmag_q  <= tot_q[3*SLO+MW+1] ? (3*SLO+MW+1)'('0 - tot_q)
                                   : tot_q[3*SLO+MW:0];
      // divide by six, most significant digit first
      d6_q[0] <= d6_in;
      for (int j = 0; j < ND6; j++) begin
        d6_q[j+1] <= d6_step(d6_q[j], d6_q[j].dd[D6W-1-8*j -: 8]);
      end
      // saturation to 64 bits
      if (d6_q[ND6].neg) begin
        if ((|d6_q[ND6].quot[D6W-1:OUT_W]) ||
            (d6_q[ND6].quot[OUT_W-1] && (|d6_q[ND6].quot[OUT_W-2:0]))) begin
          out_q <= {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
          out_q <= '0 - d6_q[ND6].quot[OUT_W-1:0];
        end
      end else begin
        if ((|d6_q[ND6].quot[D6W-1:OUT_W]) || d6_q[ND6].quot[OUT_W-1]) begin
          out_q <= {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
          out_q <= d6_q[ND6].quot[OUT_W-1:0];
        end
      end
    end
  end

  `TNRI_ASSERT_IMP(a_back_t_range, clk_i, rst_ni, vld_q[NDIV] && (geo_q[NDIV].kind == KIND_ONE || geo_q[NDIV].kind == KIND_TWO), dvb_q[NDIV].q <= TW'(1 << 30) && dva_q[NDIV].q <= TW'(1 << 30), "crossing parameter above one")
  `TNRI_ASSERT_IMP(a_back_out_source, clk_i, rst_ni, $rose(out_vld_q), $past(vld_q[NSTG-1]), "result beat without a pipeline item")

endmodule

### hw/rtl/triangle_negative_region_integral.sv
// ----------------------------------------------------------------------------
// triangle_negative_region_integral
// integral of a linear function over the negative level set part of a triangle
// ----------------------------------------------------------------------------
// channel   | dir | payload                                  | handshake
// ----------+-----+------------------------------------------+----------------
// s_t*      | in  | 12 x 32 bit: v0x v0y v1x v1y v2x v2y,    | tvalid/tready
//           |     | value0..2, level0..2 (q16.16)            |
// m_t*      | out | integral_value, 64 bit q48.16, saturated | tvalid/tready
// cfg_*     | in  | near_zero_threshold, 16 bit              | write enable
//
// one beat per cycle is taken unless the classifier's last stage holds a job
// while the queue is full; classifier, queue and arithmetic pipeline are all
// registered, and the arithmetic pipeline length is mostly set by the 31 stage
// crossing divider and the 9 stage divide by six; both sides stall on their
// own, the two entry queue soaks up the difference
// reset clears all valid flags and sets the threshold to one lsb
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_negative_region_integral #(
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input beat
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // [31:0] vertex0_x, [63:32] vertex0_y, [95:64] vertex1_x,
  // [127:96] vertex1_y, [159:128] vertex2_x, [191:160] vertex2_y,
  // [223:192] value0, [255:224] value1, [287:256] value2,
  // [319:288] level0, [351:320] level1, [383:352] level2
  input  logic [383:0] s_tdata_i,
  // result beat
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // [63:0] integral_value
  output logic [63:0]  m_tdata_o,
  // threshold register
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);
  import tnri_pkg::*;

  logic [THR_W-1:0] thr_q;   // near zero threshold
  logic             push;    // classifier hands a job to the queue
  logic             full;
  logic             pop;     // arithmetic pipeline takes a job
  logic             jvld;
  job_t             job_f;   // job from the classifier
  job_t             job_b;   // job at the head of the queue

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // sign extend, nudge, sort by level, pick crossing edges
  tnri_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .thr_i      (thr_q),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_f)
  );

  // decouples the classifier from the arithmetic stall
  tnri_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_f),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (jvld),
    .job_o  (job_b)
  );

  // divide, interpolate, sum sub-triangles, scale and saturate
  tnri_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .jvld_i     (jvld),
    .job_i      (job_b),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule
